// ----- src/mhpq_pkg.sv -----
// Shared types and codes for the binary max-heap priority queue.
package mhpq_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // commands from the controller, at most one per controller step
    typedef struct packed {
        logic start;     // beat accepted: latch key, hole and status, update count, issue first reads
        logic rm_load;   // root and last entry arrived
        logic up_read;   // sift-up: read parent of the hole
        logic up_cmp;    // sift-up: compare key with parent
        logic dn_read;   // sift-down: read children of the hole
        logic dn_cmp;    // sift-down: compare key with larger child
        logic finish;    // load the output register
    } t_dp_cmd;

    // status back from the datapath
    typedef struct packed {
        logic full;
        logic empty;
        logic last;       // heap became empty on remove
        logic hole_zero;  // hole sits at the root
        logic up_move;    // parent smaller than key
        logic dn_leaf;    // hole has no child
        logic dn_move;    // larger child greater than key
    } t_dp_stat;

endpackage

// ----- src/mhpq_ctrl.sv -----
// Controller state machine for the heap queue: sequences insert and remove.
module mhpq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_operation,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  mhpq_pkg::t_dp_stat  i_stat,
    output mhpq_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RM_LD  = 7'b0000010,
        S_UP_RD  = 7'b0000100,
        S_UP_CMP = 7'b0001000,
        S_DN_RD  = 7'b0010000,
        S_DN_CMP = 7'b0100000,
        S_FIN    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_operation == mhpq_pkg::OP_REMOVE) begin
                        n_state = i_stat.empty ? S_FIN : S_RM_LD;
                    end else begin
                        n_state = i_stat.full ? S_FIN : S_UP_RD;
                    end
                end
            end
            S_RM_LD: begin
                o_cmd.rm_load = 1'b1;
                n_state = i_stat.last ? S_FIN : S_DN_RD;
            end
            S_UP_RD: begin
                o_cmd.up_read = 1'b1;
                n_state = i_stat.hole_zero ? S_FIN : S_UP_CMP;
            end
            S_UP_CMP: begin
                o_cmd.up_cmp = 1'b1;
                n_state = i_stat.up_move ? S_UP_RD : S_FIN;
            end
            S_DN_RD: begin
                o_cmd.dn_read = 1'b1;
                n_state = i_stat.dn_leaf ? S_FIN : S_DN_CMP;
            end
            S_DN_CMP: begin
                o_cmd.dn_cmp = 1'b1;
                n_state = i_stat.dn_move ? S_DN_RD : S_FIN;
            end
            S_FIN: begin
                // hold until the previous result has left
                if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_fin_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid && r_state == S_IDLE)
        else $error("finish did not present a result");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.start && !(i_operation == mhpq_pkg::OP_INSERT && i_stat.full)
                     && !(i_operation == mhpq_pkg::OP_REMOVE && i_stat.empty))
        |=> !o_in_ready)
        else $error("accepted a beat during a sift");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command");

endmodule

// ----- src/mhpq_dp.sv -----
// Datapath for the heap queue: key store, fill count, hole walk and result register.
module mhpq_dp #(
    parameter int DEPTH = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mhpq_pkg::t_dp_cmd                   i_cmd,
    input  logic                                i_operation,
    input  logic signed [mhpq_pkg::KEY_W-1:0]   i_key_value,
    output mhpq_pkg::t_dp_stat                  o_stat,
    output logic signed [mhpq_pkg::KEY_W-1:0]   o_removed_key,
    output logic [1:0]                          o_status,
    output logic [mhpq_pkg::COUNT_W-1:0]        o_element_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = AW + 2;   // wide enough for both child indexes

    logic [mhpq_pkg::KEY_W-1:0] mem [DEPTH];

    logic [CW-1:0]                      r_count;
    logic [AW-1:0]                      r_hole;
    logic signed [mhpq_pkg::KEY_W-1:0]  r_key;
    logic signed [mhpq_pkg::KEY_W-1:0]  r_removed;
    mhpq_pkg::t_status                  r_status;
    logic [mhpq_pkg::KEY_W-1:0]         r_rda, r_rdb;
    logic signed [mhpq_pkg::KEY_W-1:0]  r_out_key;
    logic [1:0]                         r_out_status;
    logic [mhpq_pkg::COUNT_W-1:0]       r_out_count;

    logic [AW-1:0]                  w_parent;
    logic [XW-1:0]                  w_left, w_right, w_count_x;
    logic                           w_right_ok, w_pick_right;
    logic [mhpq_pkg::KEY_W-1:0]     w_child;
    logic [AW-1:0]                  w_child_idx;
    logic [AW-1:0]                  w_ra, w_rb, w_wa;
    logic [mhpq_pkg::KEY_W-1:0]     w_wd;
    logic                           w_we;

    assign w_parent   = (r_hole - AW'(1)) >> 1;
    assign w_left     = XW'({r_hole, 1'b1});
    assign w_right    = w_left + XW'(1);
    assign w_count_x  = XW'(r_count);
    assign w_right_ok = w_right < w_count_x;
    assign w_pick_right = w_right_ok && ($signed(r_rdb) > $signed(r_rda));
    assign w_child     = w_pick_right ? r_rdb : r_rda;
    assign w_child_idx = w_pick_right ? w_right[AW-1:0] : w_left[AW-1:0];

    assign o_stat.full      = (r_count == CW'(DEPTH));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.last      = (r_count == '0);
    assign o_stat.hole_zero = (r_hole == '0);
    assign o_stat.up_move   = r_key > $signed(r_rda);
    assign o_stat.dn_leaf   = w_left >= w_count_x;
    assign o_stat.dn_move   = $signed(w_child) > r_key;

    // read addresses
    always_comb begin
        w_ra = '0;
        w_rb = AW'(r_count - CW'(1));
        if (i_cmd.up_read) begin
            w_ra = w_parent;
        end else if (i_cmd.dn_read) begin
            w_ra = w_left[AW-1:0];
            w_rb = w_right[AW-1:0];
        end
    end

    // hole writes: move a neighbor into the hole, or drop the key into it
    always_comb begin
        w_we = 1'b0;
        w_wa = r_hole;
        w_wd = r_key;
        if (i_cmd.up_read && o_stat.hole_zero) begin
            w_we = 1'b1;
        end else if (i_cmd.up_cmp) begin
            w_we = 1'b1;
            if (o_stat.up_move) begin
                w_wd = r_rda;
            end
        end else if (i_cmd.dn_read && o_stat.dn_leaf) begin
            w_we = 1'b1;
        end else if (i_cmd.dn_cmp) begin
            w_we = 1'b1;
            if (o_stat.dn_move) begin
                w_wd = w_child;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_rda <= mem[w_ra];
        r_rdb <= mem[w_rb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.start) begin
            if (i_operation == mhpq_pkg::OP_INSERT && !o_stat.full) begin
                r_count <= r_count + CW'(1);
            end else if (i_operation == mhpq_pkg::OP_REMOVE && !o_stat.empty) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key     <= i_key_value;
            r_hole    <= AW'(r_count);
            r_removed <= '0;
            if (i_operation == mhpq_pkg::OP_INSERT) begin
                r_status <= o_stat.full ? mhpq_pkg::ST_FULL : mhpq_pkg::ST_OK;
            end else begin
                r_status <= o_stat.empty ? mhpq_pkg::ST_EMPTY : mhpq_pkg::ST_OK;
            end
        end
        if (i_cmd.rm_load) begin
            r_removed <= $signed(r_rda);
            r_key     <= $signed(r_rdb);
            r_hole    <= '0;
        end
        if (i_cmd.up_cmp && o_stat.up_move) begin
            r_hole <= w_parent;
        end
        if (i_cmd.dn_cmp && o_stat.dn_move) begin
            r_hole <= w_child_idx;
        end
        if (i_cmd.finish) begin
            r_out_key    <= r_removed;
            r_out_status <= r_status;
            r_out_count  <= mhpq_pkg::COUNT_W'(r_count);
        end
    end

    assign o_removed_key   = r_out_key;
    assign o_status        = r_out_status;
    assign o_element_count = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start && i_operation == mhpq_pkg::OP_INSERT && !o_stat.full)
        |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the count");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start && i_operation == mhpq_pkg::OP_REMOVE && !o_stat.empty)
        |=> r_count == $past(r_count) - CW'(1))
        else $error("remove did not shrink the count");

    a_hole_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.up_read || i_cmd.dn_read) |-> CW'(r_hole) < r_count)
        else $error("hole outside the filled part of the heap");

endmodule

// ----- src/max_heap_priority_queue.sv -----
// Top level of the binary max-heap priority queue.
// Holds up to DEPTH signed 32-bit keys in one two-read, one-write memory laid
// out as a binary max-heap. Each beat inserts a key (operation 0) or removes the
// maximum (operation 1) and yields one result beat with the removed key, a status
// and the count after the operation. One item is worked at a time. An insert
// walks the hole up from the new last slot; a remove takes the root, moves the
// last key into the root and walks the hole down. Each level the key moves
// takes a memory read followed by the compare and hole write. Removing the only
// key needs no walk. The input is ready again in the same cycle that the result
// is offered. Insert into a full heap and remove from an empty one skip the walk
// and leave the heap unchanged. While an earlier result still waits at the
// output, the item holds in its last step and the input stays blocked. The store
// needs no clearing after reset; only entries below the count are ever used.
module max_heap_priority_queue #(
    parameter int DEPTH = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_operation,
    input  logic signed [mhpq_pkg::KEY_W-1:0]   i_key_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [mhpq_pkg::KEY_W-1:0]   o_removed_key,
    output logic [1:0]                          o_status,
    output logic [mhpq_pkg::COUNT_W-1:0]        o_element_count
);

    mhpq_pkg::t_dp_cmd  w_cmd;
    mhpq_pkg::t_dp_stat w_stat;

    mhpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    mhpq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_operation     (i_operation),
        .i_key_value     (i_key_value),
        .o_stat          (w_stat),
        .o_removed_key   (o_removed_key),
        .o_status        (o_status),
        .o_element_count (o_element_count)
    );

endmodule

// ----- sim/max_heap_priority_queue_test.sv -----
// Testbench for the max-heap priority queue: directed and random traffic checked against a heap model.
`timescale 1ns / 100ps

module max_heap_priority_queue_test;
    import mhpq_pkg::*;

    localparam int HEAP_DEPTH   = 128;
    localparam int RANDOM_BEATS = 1630;
    localparam int HOLD_CYCLES  = 500;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        t_status                 status;
        logic [COUNT_W-1:0]      count;
    } heap_result_t;

    class heap_scoreboard;
        logic signed [KEY_W-1:0] keys [HEAP_DEPTH];
        int unsigned             fill;
        heap_result_t            due [$];
        int                      errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        // apply one accepted beat to the model heap and queue its result
        function void note_beat(logic op, logic signed [KEY_W-1:0] key);
            heap_result_t            res;
            int unsigned             idx;
            int unsigned             par;
            int unsigned             kid;
            logic signed [KEY_W-1:0] tmp;
            res.key    = '0;
            res.status = ST_OK;
            if (op == OP_INSERT) begin
                if (fill >= HEAP_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    idx       = fill;
                    keys[idx] = key;
                    fill++;
                    while (idx > 0) begin
                        par = (idx - 1) / 2;
                        if (!(keys[idx] > keys[par])) break;
                        tmp       = keys[idx];
                        keys[idx] = keys[par];
                        keys[par] = tmp;
                        idx       = par;
                    end
                end
            end else begin
                if (fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.key = keys[0];
                    fill--;
                    if (fill > 0) begin
                        keys[0] = keys[fill];
                        idx     = 0;
                        while (2 * idx + 1 < fill) begin
                            kid = 2 * idx + 1;
                            // left child wins a tie
                            if (kid + 1 < fill && keys[kid + 1] > keys[kid]) kid++;
                            if (!(keys[kid] > keys[idx])) break;
                            tmp       = keys[idx];
                            keys[idx] = keys[kid];
                            keys[kid] = tmp;
                            idx       = kid;
                        end
                    end
                end
            end
            res.count = fill[COUNT_W-1:0];
            due.push_back(res);
        endfunction

        function void check_result(logic signed [KEY_W-1:0] key, logic [1:0] status,
                                   logic [COUNT_W-1:0] count);
            heap_result_t exp_res;
            if (due.size() == 0) begin
                $error("result beat with no operation pending");
                errors++;
                return;
            end
            exp_res = due.pop_front();
            if (key !== exp_res.key) begin
                $error("removed_key: expected %0d, got %0d", exp_res.key, key);
                errors++;
            end
            if (status !== exp_res.status) begin
                $error("status: expected %0d, got %0d", exp_res.status, status);
                errors++;
            end
            if (count !== exp_res.count) begin
                $error("element_count: expected %0d, got %0d", exp_res.count, count);
                errors++;
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      i_in_valid      = 1'b0;
    logic                      o_in_ready;
    logic                      i_operation     = OP_INSERT;
    logic signed [KEY_W-1:0]   i_key_value     = '0;
    logic                      o_out_valid;
    logic                      i_out_ready     = 1'b0;
    logic signed [KEY_W-1:0]   o_removed_key;
    logic [1:0]                o_status;
    logic [COUNT_W-1:0]        o_element_count;

    heap_scoreboard board = new();
    int             sent_beats = 0;
    int             burst_left = 0;
    int             level      = 0;

    max_heap_priority_queue #(
        .DEPTH(HEAP_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_key_value     (i_key_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_removed_key   (o_removed_key),
        .o_status        (o_status),
        .o_element_count (o_element_count)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) board.note_beat(i_operation, i_key_value);
            if (o_out_valid && i_out_ready)
                board.check_result(o_removed_key, o_status, o_element_count);
        end
    end

    // mix of extremes, tight ranges for ties, and full-width random keys
    function automatic logic signed [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0:       k = 32'sh8000_0000;
            1:       k = 32'sh7fff_ffff;
            2, 3:    k = $urandom_range(0, 15) - 8;
            4:       k = ($urandom_range(0, 1) != 0) ? '0 : '1;
            default: k = $urandom;
        endcase
        return k;
    endfunction

    // offer one beat, with a random gap at burst boundaries; hold until accepted
    task automatic send_beat(input logic op, input logic signed [KEY_W-1:0] key);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_key_value <= key;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        sent_beats++;
        if (op == OP_INSERT) begin
            if (level < HEAP_DEPTH) level++;
        end else if (level > 0) begin
            level--;
        end
    endtask

    task automatic fill_up();
        while (level < HEAP_DEPTH) send_beat(OP_INSERT, pick_key());
        repeat (3) send_beat(OP_INSERT, pick_key());
    endtask

    task automatic drain();
        while (level > 0) send_beat(OP_REMOVE, $urandom);
        repeat (2) send_beat(OP_REMOVE, $urandom);
    endtask

    task automatic mixed_run(input int insert_pct);
        int n;
        n = $urandom_range(30, 150);
        repeat (n) begin
            if ($urandom_range(0, 99) < insert_pct) send_beat(OP_INSERT, pick_key());
            else send_beat(OP_REMOVE, $urandom);
        end
    endtask

    // receiver: random stall patterns plus one long hold-off to back up the input
    initial begin
        int  seg_len;
        int  mode;
        bit  held;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held && sent_beats >= 400) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                held = 1'b1;
            end
            seg_len = $urandom_range(10, 60);
            mode    = $urandom_range(0, 3);
            repeat (seg_len) begin
                @(negedge i_clk);
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 99) < 70);
                    2: i_out_ready <= ($urandom_range(0, 99) < 30);
                    default: i_out_ready <= ~i_out_ready;
                endcase
            end
        end
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int mode;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: remove from empty, extreme and tied keys, drain past empty
        send_beat(OP_REMOVE, 32'sh1234_5678);
        send_beat(OP_INSERT, '0);
        send_beat(OP_INSERT, 32'sh7fff_ffff);
        send_beat(OP_INSERT, 32'sh8000_0000);
        send_beat(OP_INSERT, -1);
        send_beat(OP_INSERT, 1);
        send_beat(OP_INSERT, 5);
        send_beat(OP_INSERT, 5);
        send_beat(OP_INSERT, 5);
        repeat (9) send_beat(OP_REMOVE, $urandom);

        // random: full-and-empty sweeps mixed with biased runs
        fill_up();
        drain();
        while (sent_beats < RANDOM_BEATS) begin
            mode = $urandom_range(0, 7);
            case (mode)
                0:       fill_up();
                1:       drain();
                2, 3:    mixed_run(80);
                4, 5:    mixed_run(25);
                default: mixed_run(50);
            endcase
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (board.errors == 0 && board.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
